// File: design/m3inv_pkg.sv
`default_nettype none

package m3inv_pkg;

    // Number format: two's complement entries with FRAC_BITS fraction bits
    localparam int FRAC_BITS = 16;
    localparam int ENT_W     = 32;
    localparam int N_ENT     = 9;
    localparam int THR_W     = ENT_W - 1;

    // Exact intermediate widths
    localparam int PROD_W = 2 * ENT_W;            // entry times entry
    localparam int ADJ_W  = PROD_W;               // cofactor, signed, exact
    localparam int AMAG_W = ADJ_W - 1;            // cofactor magnitude
    localparam int DET_W  = ADJ_W + ENT_W + 1;    // three-term determinant, signed
    localparam int DMAG_W = DET_W;                // determinant magnitude
    localparam int RND_SH = 2 * FRAC_BITS;        // scale between det and output
    localparam int DQ_W   = DMAG_W + 1 - RND_SH;  // rounded determinant magnitude

    // Divider: quotient bits kept below the saturation point
    localparam int QBITS = ENT_W + 1;
    localparam int Q_W   = QBITS + 1;
    localparam int NUM_W = AMAG_W + RND_SH;
    localparam int P_W   = NUM_W - QBITS;
    localparam int CMP_W = (P_W > DMAG_W) ? P_W : DMAG_W;
    localparam int SAT_W = (DQ_W > Q_W) ? DQ_W : Q_W;

    // Pipeline depths
    localparam int DET_STAGES = 9;
    localparam int DIV_STAGES = QBITS + 2;
    localparam int TOTAL_LAT  = DET_STAGES + DIV_STAGES + 1;

    // Determinant magnitude limits after saturation
    localparam logic [DQ_W-1:0] DQ_LIM_POS = {{(DQ_W-ENT_W+1){1'b0}}, {(ENT_W-1){1'b1}}};
    localparam logic [DQ_W-1:0] DQ_LIM_NEG = DQ_LIM_POS + DQ_W'(1);

    // Cofactor k = e[A]*e[B] - e[C]*e[D], entries in row-major order
    localparam int ADJ_A [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int ADJ_B [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int ADJ_C [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int ADJ_D [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic signed [ENT_W-1:0] in_r1c1;
        logic signed [ENT_W-1:0] in_r1c2;
        logic signed [ENT_W-1:0] in_r1c3;
        logic signed [ENT_W-1:0] in_r2c1;
        logic signed [ENT_W-1:0] in_r2c2;
        logic signed [ENT_W-1:0] in_r2c3;
        logic signed [ENT_W-1:0] in_r3c1;
        logic signed [ENT_W-1:0] in_r3c2;
        logic signed [ENT_W-1:0] in_r3c3;
    } m3inv_in_t;

    typedef struct packed {
        logic signed [ENT_W-1:0] out_r1c1;
        logic signed [ENT_W-1:0] out_r1c2;
        logic signed [ENT_W-1:0] out_r1c3;
        logic signed [ENT_W-1:0] out_r2c1;
        logic signed [ENT_W-1:0] out_r2c2;
        logic signed [ENT_W-1:0] out_r2c3;
        logic signed [ENT_W-1:0] out_r3c1;
        logic signed [ENT_W-1:0] out_r3c2;
        logic signed [ENT_W-1:0] out_r3c3;
        logic signed [ENT_W-1:0] determinant;
        logic                    singular;
    } m3inv_out_t;

    typedef logic [N_ENT-1:0][ENT_W-1:0] m3inv_ents_t;

    typedef struct packed {
        logic [N_ENT-1:0][AMAG_W-1:0] amag;
        logic [N_ENT-1:0]             aneg;
    } m3inv_lanes_t;

    typedef struct packed {
        m3inv_in_t         matrix;
        logic [ENT_W-1:0]  det;
        logic              singular;
    } m3inv_side_t;

    typedef struct packed {
        m3inv_lanes_t      lanes;
        logic [DMAG_W-1:0] dmag;
        logic              dneg;
    } m3inv_div_req_t;

    typedef struct packed {
        logic [N_ENT-1:0][Q_W-1:0] q;
        logic [N_ENT-1:0]          ovf;
        logic [N_ENT-1:0]          neg;
    } m3inv_quot_t;

    function automatic m3inv_ents_t to_ents(input m3inv_in_t m);
        m3inv_ents_t e;
        e[0] = m.in_r1c1;
        e[1] = m.in_r1c2;
        e[2] = m.in_r1c3;
        e[3] = m.in_r2c1;
        e[4] = m.in_r2c2;
        e[5] = m.in_r2c3;
        e[6] = m.in_r3c1;
        e[7] = m.in_r3c2;
        e[8] = m.in_r3c3;
        return e;
    endfunction

    // Sign and magnitude to a saturated two's complement word
    function automatic logic [ENT_W-1:0] sat_word(input logic [SAT_W-1:0] mag,
                                                  input logic neg);
        logic [SAT_W-1:0] lim_pos;
        logic [SAT_W-1:0] lim_neg;
        logic [ENT_W-1:0] res;
        lim_pos = {{(SAT_W-ENT_W+1){1'b0}}, {(ENT_W-1){1'b1}}};
        lim_neg = lim_pos + SAT_W'(1);
        priority if (neg && (mag > lim_neg))
        begin
            res = {1'b1, {(ENT_W-1){1'b0}}};
        end
        else if (neg)
        begin
            res = ~mag[ENT_W-1:0] + ENT_W'(1);
        end
        else if (mag > lim_pos)
        begin
            res = {1'b0, {(ENT_W-1){1'b1}}};
        end
        else
        begin
            res = mag[ENT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/matrix3_inverse_unit.sv
`default_nettype none

// 3x3 matrix inverse by the adjugate, signed Q16.16 entries. One matrix may be
// started in every clock cycle: busy never rises, and each result appears with
// done after the cofactor and determinant arithmetic, then a bit-per-stage
// divider that forms all nine inverse entries in parallel, then one output
// register. The result is shown for a single cycle and cannot be held off,
// so the receiver must take every done pulse.
// The inverse entries are round(adj / det), ties away from zero, and saturate
// to 32 bits, as does the determinant. When the rounded determinant magnitude
// is at or below the singular threshold, the input matrix comes back unchanged
// with singular set. The threshold register transfers on cfg_valid (cfg_ready
// is always high); write it only while no matrix is in flight.
module matrix3_inverse_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  m3inv_pkg::m3inv_in_t          matrix,
    output logic                          done,
    output m3inv_pkg::m3inv_out_t         result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [m3inv_pkg::THR_W-1:0]   cfg_data
);

    logic [m3inv_pkg::THR_W-1:0] thr_reg;

    logic                      det_valid;
    m3inv_pkg::m3inv_side_t    det_side;
    m3inv_pkg::m3inv_div_req_t div_req;

    logic                      div_valid;
    m3inv_pkg::m3inv_side_t    div_side;
    m3inv_pkg::m3inv_quot_t    quot;

    m3inv_pkg::m3inv_ents_t    pass_ents;
    m3inv_pkg::m3inv_ents_t    sel_ents;
    m3inv_pkg::m3inv_out_t     result_next;
    m3inv_pkg::m3inv_out_t     result_reg;
    logic                      done_reg;

    // The pipeline never stalls: accept on every start
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Threshold register: take the transfer whenever it is offered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // Cofactors, determinant, rounding and singular decision
    m3inv_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .matrix    (matrix),
        .thr       (thr_reg),
        .out_valid (det_valid),
        .side      (det_side),
        .req       (div_req)
    );

    // Nine parallel restoring dividers, matrix and determinant ride alongside
    m3inv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (det_valid),
        .req       (div_req),
        .side_in   (det_side),
        .out_valid (div_valid),
        .side_out  (div_side),
        .quot      (quot)
    );

    // Output stage: saturate the quotients, or pass the matrix back if singular
    assign pass_ents = m3inv_pkg::to_ents(div_side.matrix);

    for (genvar k = 0; k < m3inv_pkg::N_ENT; k++)
    begin : g_sel
        assign sel_ents[k] = div_side.singular ? pass_ents[k]
            : m3inv_pkg::sat_word(quot.ovf[k] ? '1 : m3inv_pkg::SAT_W'(quot.q[k]),
                                  quot.neg[k]);
    end

    always_comb
    begin
        result_next.out_r1c1    = sel_ents[0];
        result_next.out_r1c2    = sel_ents[1];
        result_next.out_r1c3    = sel_ents[2];
        result_next.out_r2c1    = sel_ents[3];
        result_next.out_r2c2    = sel_ents[4];
        result_next.out_r2c3    = sel_ents[5];
        result_next.out_r3c1    = sel_ents[6];
        result_next.out_r3c2    = sel_ents[7];
        result_next.out_r3c3    = sel_ents[8];
        result_next.determinant = div_side.det;
        result_next.singular    = div_side.singular;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every done pulse traces back to a start a fixed latency earlier
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, m3inv_pkg::TOTAL_LAT))
        else $error("result without a matching start");

    // Every start produces its result after the fixed latency
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(m3inv_pkg::TOTAL_LAT) done)
        else $error("start without a result");

    // A zero determinant is always reported as singular
    a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.determinant == '0) |-> result.singular)
        else $error("zero determinant not flagged singular");

endmodule

`default_nettype wire

// File: design/m3inv_det.sv
`default_nettype none

module m3inv_det (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  m3inv_pkg::m3inv_in_t       matrix,
    input  logic [m3inv_pkg::THR_W-1:0] thr,
    output logic                       out_valid,
    output m3inv_pkg::m3inv_side_t     side,
    output m3inv_pkg::m3inv_div_req_t  req
);

    localparam int NE = m3inv_pkg::N_ENT;

    logic [m3inv_pkg::DET_STAGES-1:0] vld_reg;
    m3inv_pkg::m3inv_in_t             mat_reg [m3inv_pkg::DET_STAGES];

    m3inv_pkg::m3inv_ents_t ents_in;
    m3inv_pkg::m3inv_ents_t ents_s2;

    logic signed [m3inv_pkg::PROD_W-1:0] pa_next [NE];
    logic signed [m3inv_pkg::PROD_W-1:0] pb_next [NE];
    logic signed [m3inv_pkg::PROD_W-1:0] pa_reg  [NE];
    logic signed [m3inv_pkg::PROD_W-1:0] pb_reg  [NE];
    logic signed [m3inv_pkg::ADJ_W-1:0]  adj_reg [NE];

    logic signed [m3inv_pkg::PROD_W-1:0] ph_next [3];
    logic signed [m3inv_pkg::PROD_W:0]   pl_next [3];
    logic signed [m3inv_pkg::PROD_W-1:0] ph_reg  [3];
    logic signed [m3inv_pkg::PROD_W:0]   pl_reg  [3];
    m3inv_pkg::m3inv_lanes_t             lanes_next;
    m3inv_pkg::m3inv_lanes_t             lanes_reg [2:m3inv_pkg::DET_STAGES-1];

    logic [m3inv_pkg::DET_W-1:0] term_next [3];
    logic [m3inv_pkg::DET_W-1:0] term_reg  [3];
    logic [m3inv_pkg::DET_W-1:0] s01_reg;
    logic [m3inv_pkg::DET_W-1:0] t2_reg;
    logic [m3inv_pkg::DET_W-1:0] det_reg;

    logic                         dneg7_reg;
    logic [m3inv_pkg::DMAG_W-1:0] dmag7_reg;
    logic                         dneg8_reg;
    logic [m3inv_pkg::DMAG_W-1:0] dmag8_reg;
    logic [m3inv_pkg::DQ_W-1:0]   dq8_reg;
    logic                         dneg9_reg;
    logic [m3inv_pkg::DMAG_W-1:0] dmag9_reg;
    logic [m3inv_pkg::ENT_W-1:0]  detbits9_reg;
    logic                         sing9_reg;

    logic [m3inv_pkg::DMAG_W:0]   rnd_sum;
    logic [m3inv_pkg::DQ_W-1:0]   dq_lim;
    logic [m3inv_pkg::DQ_W-1:0]   dq_abs;
    logic [m3inv_pkg::ENT_W-1:0]  detbits_next;
    logic                         sing_next;

    assign ents_in = m3inv_pkg::to_ents(matrix);
    assign ents_s2 = m3inv_pkg::to_ents(mat_reg[1]);

    // Cofactor products and per-lane magnitudes
    for (genvar k = 0; k < NE; k++)
    begin : g_cof
        assign pa_next[k] = $signed(ents_in[m3inv_pkg::ADJ_A[k]])
                          * $signed(ents_in[m3inv_pkg::ADJ_B[k]]);
        assign pb_next[k] = $signed(ents_in[m3inv_pkg::ADJ_C[k]])
                          * $signed(ents_in[m3inv_pkg::ADJ_D[k]]);
        assign lanes_next.aneg[k] = adj_reg[k][m3inv_pkg::ADJ_W-1];
        assign lanes_next.amag[k] = adj_reg[k][m3inv_pkg::ADJ_W-1]
                                  ? m3inv_pkg::AMAG_W'(-adj_reg[k])
                                  : m3inv_pkg::AMAG_W'(adj_reg[k]);
    end

    // First-row expansion, cofactor split in two halves
    for (genvar j = 0; j < 3; j++)
    begin : g_row
        assign ph_next[j] = $signed(ents_s2[j])
            * $signed(adj_reg[3*j][m3inv_pkg::ADJ_W-1:m3inv_pkg::ENT_W]);
        assign pl_next[j] = $signed(ents_s2[j])
            * $signed({1'b0, adj_reg[3*j][m3inv_pkg::ENT_W-1:0]});
        assign term_next[j] =
            ({{(m3inv_pkg::DET_W-m3inv_pkg::PROD_W){ph_reg[j][m3inv_pkg::PROD_W-1]}},
              ph_reg[j]} << m3inv_pkg::ENT_W)
          + {{(m3inv_pkg::DET_W-m3inv_pkg::PROD_W-1){pl_reg[j][m3inv_pkg::PROD_W]}},
             pl_reg[j]};
    end

    always_comb
    begin
        rnd_sum      = {1'b0, dmag7_reg}
                     + ((m3inv_pkg::DMAG_W+1)'(1) << (m3inv_pkg::RND_SH - 1));
        dq_lim       = dneg8_reg ? m3inv_pkg::DQ_LIM_NEG : m3inv_pkg::DQ_LIM_POS;
        dq_abs       = (dq8_reg > dq_lim) ? dq_lim : dq8_reg;
        detbits_next = m3inv_pkg::sat_word(m3inv_pkg::SAT_W'(dq8_reg), dneg8_reg);
        sing_next    = dq_abs <= m3inv_pkg::DQ_W'(thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[m3inv_pkg::DET_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        mat_reg[0] <= matrix;
        for (int s = 1; s < m3inv_pkg::DET_STAGES; s++)
        begin
            mat_reg[s] <= mat_reg[s-1];
        end
        for (int k = 0; k < NE; k++)
        begin
            pa_reg[k]  <= pa_next[k];
            pb_reg[k]  <= pb_next[k];
            adj_reg[k] <= pa_reg[k] - pb_reg[k];
        end
        for (int j = 0; j < 3; j++)
        begin
            ph_reg[j]   <= ph_next[j];
            pl_reg[j]   <= pl_next[j];
            term_reg[j] <= term_next[j];
        end
        lanes_reg[2] <= lanes_next;
        for (int s = 3; s < m3inv_pkg::DET_STAGES; s++)
        begin
            lanes_reg[s] <= lanes_reg[s-1];
        end
        s01_reg      <= term_reg[0] + term_reg[1];
        t2_reg       <= term_reg[2];
        det_reg      <= s01_reg + t2_reg;
        dneg7_reg    <= det_reg[m3inv_pkg::DET_W-1];
        dmag7_reg    <= det_reg[m3inv_pkg::DET_W-1] ? -det_reg : det_reg;
        dneg8_reg    <= dneg7_reg;
        dmag8_reg    <= dmag7_reg;
        dq8_reg      <= rnd_sum[m3inv_pkg::DMAG_W:m3inv_pkg::RND_SH];
        dneg9_reg    <= dneg8_reg;
        dmag9_reg    <= dmag8_reg;
        detbits9_reg <= detbits_next;
        sing9_reg    <= sing_next;
    end

    assign out_valid     = vld_reg[m3inv_pkg::DET_STAGES-1];
    assign side.matrix   = mat_reg[m3inv_pkg::DET_STAGES-1];
    assign side.det      = detbits9_reg;
    assign side.singular = sing9_reg;
    assign req.lanes     = lanes_reg[m3inv_pkg::DET_STAGES-1];
    assign req.dmag      = dmag9_reg;
    assign req.dneg      = dneg9_reg;

endmodule

`default_nettype wire

// File: design/m3inv_div.sv
`default_nettype none

module m3inv_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  m3inv_pkg::m3inv_div_req_t req,
    input  m3inv_pkg::m3inv_side_t    side_in,
    output logic                      out_valid,
    output m3inv_pkg::m3inv_side_t    side_out,
    output m3inv_pkg::m3inv_quot_t    quot
);

    localparam int NE = m3inv_pkg::N_ENT;
    localparam int NS = m3inv_pkg::DIV_STAGES;
    localparam int QB = m3inv_pkg::QBITS;
    localparam int DW = m3inv_pkg::DMAG_W;

    logic [NS-1:0]          vld_reg;
    m3inv_pkg::m3inv_side_t side_reg [NS];
    logic [NE-1:0]          neg_reg  [NS];
    logic [NE-1:0]          ovf_reg  [NS];
    logic [DW-1:0]          d_reg    [QB+1];
    logic [DW-1:0]          r_reg    [QB+1][NE];
    logic [QB-1:0]          nlo_reg  [QB+1][NE];
    logic [QB-1:0]          q_reg    [QB+1][NE];
    logic [m3inv_pkg::Q_W-1:0] qr_reg [NE];

    logic [NE-1:0] ovf_next;

    // Entry: split the scaled numerator into a high part and the bits to shift in
    for (genvar k = 0; k < NE; k++)
    begin : g_init
        logic [m3inv_pkg::NUM_W-1:0] num;
        logic [m3inv_pkg::CMP_W-1:0] p_ext;
        logic [m3inv_pkg::CMP_W-1:0] d_ext;
        assign num   = {req.lanes.amag[k], {m3inv_pkg::RND_SH{1'b0}}};
        assign p_ext = m3inv_pkg::CMP_W'(num[m3inv_pkg::NUM_W-1:QB]);
        assign d_ext = m3inv_pkg::CMP_W'(req.dmag);
        assign ovf_next[k] = p_ext >= d_ext;

        always_ff @(posedge clk)
        begin
            r_reg[0][k]   <= ovf_next[k] ? '0 : DW'(p_ext);
            nlo_reg[0][k] <= num[QB-1:0];
            q_reg[0][k]   <= '0;
        end
    end

    // One restoring step per stage and lane
    for (genvar s = 1; s <= QB; s++)
    begin : g_step
        for (genvar k = 0; k < NE; k++)
        begin : g_lane
            logic [DW:0] t;
            logic [DW:0] dx;
            logic [DW:0] diff;
            logic        ge;
            assign t    = {r_reg[s-1][k], nlo_reg[s-1][k][QB-1]};
            assign dx   = {1'b0, d_reg[s-1]};
            assign ge   = t >= dx;
            assign diff = t - dx;

            always_ff @(posedge clk)
            begin
                r_reg[s][k]   <= ge ? diff[DW-1:0] : t[DW-1:0];
                q_reg[s][k]   <= {q_reg[s-1][k][QB-2:0], ge};
                nlo_reg[s][k] <= {nlo_reg[s-1][k][QB-2:0], 1'b0};
            end
        end
    end

    // Round to nearest, ties away from zero
    for (genvar k = 0; k < NE; k++)
    begin : g_round
        logic up;
        assign up = {r_reg[QB][k], 1'b0} >= {1'b0, d_reg[QB]};

        always_ff @(posedge clk)
        begin
            qr_reg[k] <= m3inv_pkg::Q_W'(q_reg[QB][k]) + m3inv_pkg::Q_W'(up);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        neg_reg[0]  <= req.lanes.aneg ^ {NE{req.dneg}};
        ovf_reg[0]  <= ovf_next;
        d_reg[0]    <= req.dmag;
        for (int s = 1; s < NS; s++)
        begin
            side_reg[s] <= side_reg[s-1];
            neg_reg[s]  <= neg_reg[s-1];
            ovf_reg[s]  <= ovf_reg[s-1];
        end
        for (int s = 1; s <= QB; s++)
        begin
            d_reg[s] <= d_reg[s-1];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign side_out  = side_reg[NS-1];
    assign quot.ovf  = ovf_reg[NS-1];
    assign quot.neg  = neg_reg[NS-1];
    for (genvar k = 0; k < NE; k++)
    begin : g_out
        assign quot.q[k] = qr_reg[k];
    end

    // Partial remainder stays below the divisor on lane 0 when that lane has no overflow
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QB] && !ovf_reg[QB][0] |-> r_reg[QB][0] < d_reg[QB])
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
